FILE: rtl/md5_keystream_password_hiding_unit_defines.svh
// Assertion macros shared by the password hiding unit.
`ifndef MD5_KEYSTREAM_PASSWORD_HIDING_UNIT_DEFINES_SVH
`define MD5_KEYSTREAM_PASSWORD_HIDING_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define MKPH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mkph assertion failed");

// Next-cycle implication, sampled on clock and disabled in reset.
`define MKPH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mkph assertion failed");

`endif

FILE: rtl/mkph_pkg.sv
// Package with MD5 round tables, shared types and constants of the hiding unit.
`default_nettype none
package mkph_pkg;

   localparam int MAX_KEY_BYTES = 32;
   localparam int BLOCK_BYTES   = 16;

   localparam logic [31:0] MD5_INIT_A = 32'h67452301;
   localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
   localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
   localparam logic [31:0] MD5_INIT_D = 32'h10325476;

   localparam logic [2:0] CSR_KEY_WORD0    = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD1    = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD2    = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD3    = 3'd3;
   localparam logic [2:0] CSR_KEY_LENGTH   = 3'd4;
   localparam logic [2:0] CSR_IV_HIGH      = 3'd5;
   localparam logic [2:0] CSR_IV_LOW       = 3'd6;
   localparam logic [2:0] CSR_DECRYPT_MODE = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_HASH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md5_status_type;

   function automatic logic [31:0] md5_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_s(input logic [5:0] idx);
      logic [4:0] s;
      unique case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word index for each round, taken modulo 16.
   function automatic logic [3:0] md5_g(input logic [5:0] idx);
      logic [3:0] i4;
      logic [3:0] g;
      i4 = idx[3:0];
      unique case (idx[5:4])
         2'd0: g = i4;
         2'd1: g = 4'(4'd5 * i4 + 4'd1);
         2'd2: g = 4'(4'd3 * i4 + 4'd5);
         2'd3: g = 4'(4'd7 * i4);
         default: g = i4;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/mkph_md5_core.sv
// Iterative MD5 compression unit: one round per cycle over a single 64-byte block.
`default_nettype none
module mkph_md5_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [511:0]           block,
   output mkph_pkg::md5_status_type    status,
   output logic [127:0]                digest
);
   import mkph_pkg::*;

   logic        running_ff;
   logic        last_ff;
   logic        done_ff;
   logic [5:0]  round_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] msg_ff [16];
   logic [127:0] digest_ff;

   logic [31:0] f_val;
   logic [31:0] sum_val;
   logic [63:0] rot_wide;
   logic [31:0] b_in;

   always_comb begin
      unique case (round_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = 32'h0;
      endcase
      sum_val  = a_ff + f_val + md5_k(round_ff) + msg_ff[md5_g(round_ff)];
      rot_wide = {sum_val, sum_val} << md5_s(round_ff);
      b_in     = b_ff + rot_wide[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         last_ff    <= 1'b0;
         done_ff    <= 1'b0;
         round_ff   <= 6'd0;
      end else begin
         done_ff <= last_ff;
         last_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            round_ff   <= 6'd0;
         end else if (running_ff) begin
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               running_ff <= 1'b0;
               last_ff    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= MD5_INIT_A;
         b_ff <= MD5_INIT_B;
         c_ff <= MD5_INIT_C;
         d_ff <= MD5_INIT_D;
         for (int i = 0; i < 16; i++) begin
            msg_ff[i] <= block[32*i +: 32];
         end
      end else if (running_ff) begin
         a_ff <= d_ff;
         b_ff <= b_in;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
      if (last_ff) begin
         digest_ff <= {a_ff + MD5_INIT_A, b_ff + MD5_INIT_B,
                       c_ff + MD5_INIT_C, d_ff + MD5_INIT_D};
      end
   end

   assign status.busy = running_ff | last_ff;
   assign status.done = done_ff;
   assign digest      = digest_ff;

endmodule
`default_nettype wire

FILE: rtl/md5_keystream_password_hiding_unit.sv
// Top level of the MD5 keystream password hiding unit: registers, chain and sequencer.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_ready  | 16-byte block, count, start flag
//   rsp     | out       | rsp_valid / rsp_ready  | 16-byte result
//   csr     | in        | csr_write_enable       | register index and 64-bit data
//
// One word passes through these steps from acceptance until its result can be presented:
// the padded MD5 block is built, the 64 rounds of the shared round unit run, the final
// add is made, the digest is handed to the sequencer, and the result is formed and the
// chain advanced. The next word can be accepted once the sequencer is back in idle.
// The chain ties each word to the previous word's result or text, so a single word is in flight.
// A result still waiting on rsp_ready holds the next word in its final step until taken.
// Reset is synchronous and clears all configuration registers and the chain.
`default_nettype none
module md5_keystream_password_hiding_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_text_high,
   input  wire logic [63:0] req_text_low,
   input  wire logic [4:0]  req_byte_count,
   input  wire logic        req_start_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);
   import mkph_pkg::*;
   `include "md5_keystream_password_hiding_unit_defines.svh"

   state_type state_ff, state_in;

   logic [255:0] key_ff;
   logic [5:0]   key_length_ff;
   logic [127:0] iv_ff;
   logic         decrypt_ff;
   logic [127:0] chain_ff;
   logic [127:0] text_ff;
   logic         rsp_valid_ff;
   logic [127:0] rsp_ff;

   logic          accept;
   logic          finish;
   logic          core_start;
   logic [127:0]  text_pad;
   logic [5:0]    klen;
   logic [8:0]    len_bits;
   logic [511:0]  block;
   logic [127:0]  digest;
   logic [127:0]  result;
   md5_status_type core_status;

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign finish    = (state_ff == ST_FINISH) & (~rsp_valid_ff | rsp_ready);
   assign core_start = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_HASH;
         ST_HASH:   if (core_status.done) state_in = ST_FINISH;
         ST_FINISH: if (finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Bytes at or past the count are cleared; counts above 16 keep every byte.
   always_comb begin
      logic [127:0] raw;
      raw = {req_text_high, req_text_low};
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         text_pad[8*(15-i) +: 8] = (5'(i) < req_byte_count) ? raw[8*(15-i) +: 8] : 8'h00;
      end
   end

   assign klen     = (key_length_ff > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length_ff;
   assign len_bits = {3'b000, klen + 6'd16} << 3;

   // Message is key bytes, then the chain, then the 0x80 marker and the bit length.
   always_comb begin
      logic [6:0] idx;
      logic [7:0] mbyte;
      for (int j = 0; j < 64; j++) begin
         idx = 7'(j) - {1'b0, klen};
         if (7'(j) < {1'b0, klen}) begin
            mbyte = key_ff[8*(31 - 5'(j)) +: 8];
         end else if (idx < 7'd16) begin
            mbyte = chain_ff[8*(15 - idx[3:0]) +: 8];
         end else if (idx == 7'd16) begin
            mbyte = 8'h80;
         end else if (j == 56) begin
            mbyte = len_bits[7:0];
         end else if (j == 57) begin
            mbyte = {7'b0, len_bits[8]};
         end else begin
            mbyte = 8'h00;
         end
         block[8*j +: 8] = mbyte;
      end
   end

   mkph_md5_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (core_start),
      .block  (block),
      .status (core_status),
      .digest (digest)
   );

   // Digest byte 0 is the low byte of word A; result bytes are big-endian in the word.
   always_comb begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         result[8*(15-i) +: 8] = text_ff[8*(15-i) +: 8]
                               ^ digest[32*(3 - i/4) + 8*(i%4) +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         key_length_ff <= '0;
         iv_ff         <= '0;
         decrypt_ff    <= 1'b0;
         chain_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_KEY_WORD0:    key_ff[255:192] <= csr_write_data;
               CSR_KEY_WORD1:    key_ff[191:128] <= csr_write_data;
               CSR_KEY_WORD2:    key_ff[127:64]  <= csr_write_data;
               CSR_KEY_WORD3:    key_ff[63:0]    <= csr_write_data;
               CSR_KEY_LENGTH:   key_length_ff   <= csr_write_data[5:0];
               CSR_IV_HIGH:      iv_ff[127:64]   <= csr_write_data;
               CSR_IV_LOW:       iv_ff[63:0]     <= csr_write_data;
               CSR_DECRYPT_MODE: decrypt_ff      <= csr_write_data[0];
               default: ;
            endcase
         end
         if (accept && req_start_message) begin
            chain_ff <= iv_ff;
         end else if (finish) begin
            chain_ff <= decrypt_ff ? text_ff : result;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         text_ff <= text_pad;
      end
      if (finish) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_ff[127:64];
   assign rsp_result_low  = rsp_ff[63:0];

   `MKPH_ASSERT_NOW(a_ready_core_idle, req_ready, !core_status.busy)
   `MKPH_ASSERT_NOW(a_done_in_hash, core_status.done, state_ff == ST_HASH)
   `MKPH_ASSERT_NEXT(a_accept_loads, accept, state_ff == ST_LOAD && core_status.busy == 1'b0)
   `MKPH_ASSERT_NEXT(a_finish_shows, finish, rsp_valid_ff && state_ff == ST_IDLE)

endmodule
`default_nettype wire

FILE: verif/tb_md5_keystream_password_hiding_unit.sv
// Self-checking testbench of the MD5 keystream password hiding unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_md5_keystream_password_hiding_unit;
   import mkph_pkg::*;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } block_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_text_high;
   logic [63:0] req_text_low;
   logic [4:0]  req_byte_count;
   logic        req_start_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [63:0] csr_write_data;

   // Shadow of the configuration and the chain.
   logic [63:0] key_words [4];
   logic [5:0]  key_len;
   block_type   iv_value;
   logic        recover_mode;
   block_type   chain;

   block_type   expected_results [$];
   int          error_count;
   int          results_seen;
   int          words_sent;
   longint      cycle_count;
   bit          quiet_run;

   md5_keystream_password_hiding_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_text_high(req_text_high), .req_text_low(req_text_low),
      .req_byte_count(req_byte_count), .req_start_message(req_start_message),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_high(rsp_result_high), .rsp_result_low(rsp_result_low),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   // MD5 of a message of at most 48 bytes, held in one 64-byte block.
   function automatic block_type md5_digest(input logic [7:0] msg [48], input int len);
      logic [7:0]  blk [64];
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      logic [31:0] round_const [64];
      int          shifts [16];
      int          g;
      int          r;
      logic [63:0] bits;
      block_type   dig;
      round_const = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      for (int i = 0; i < len; i++) blk[i] = msg[i];
      blk[len] = 8'h80;
      bits = 64'(len) * 8;
      for (int i = 0; i < 8; i++) blk[56 + i] = bits[8 * i +: 8];
      for (int i = 0; i < 16; i++)
         m[i] = {blk[4 * i + 3], blk[4 * i + 2], blk[4 * i + 1], blk[4 * i]};
      a = MD5_INIT_A;
      b = MD5_INIT_B;
      c = MD5_INIT_C;
      d = MD5_INIT_D;
      for (int i = 0; i < 64; i++) begin
         r = i / 16;
         case (r)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rotate_left(a + f + round_const[i] + m[g], shifts[4 * r + i % 4]);
         a = t;
      end
      a += MD5_INIT_A;
      b += MD5_INIT_B;
      c += MD5_INIT_C;
      d += MD5_INIT_D;
      // Digest byte 0 is the low byte of word A and lands in the top byte.
      for (int i = 0; i < 4; i++) begin
         dig.high[63 - 8 * i -: 8]       = a[8 * i +: 8];
         dig.high[31 - 8 * i -: 8]       = b[8 * i +: 8];
         dig.low[63 - 8 * i -: 8]        = c[8 * i +: 8];
         dig.low[31 - 8 * i -: 8]        = d[8 * i +: 8];
      end
      return dig;
   endfunction

   // Works out the result of one word and advances the shadow chain.
   function automatic block_type hide_block(input block_type text, input logic [4:0] count,
                                            input logic start);
      logic [7:0]   msg [48];
      logic [127:0] chain_bits;
      logic [127:0] text_bits;
      logic [127:0] padded;
      int           klen;
      int           cnt;
      block_type    dig;
      block_type    res;
      klen = (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len;
      cnt = (count > BLOCK_BYTES) ? BLOCK_BYTES : count;
      if (start) chain = iv_value;
      for (int i = 0; i < 48; i++) msg[i] = 8'h00;
      for (int i = 0; i < klen; i++) msg[i] = key_words[i / 8][63 - 8 * (i % 8) -: 8];
      chain_bits = chain;
      for (int i = 0; i < BLOCK_BYTES; i++) msg[klen + i] = chain_bits[127 - 8 * i -: 8];
      dig = md5_digest(msg, klen + BLOCK_BYTES);
      text_bits = text;
      padded = '0;
      for (int i = 0; i < cnt; i++) padded[127 - 8 * i -: 8] = text_bits[127 - 8 * i -: 8];
      res = padded ^ dig;
      chain = recover_mode ? block_type'(padded) : res;
      return res;
   endfunction

   // The write enable stays high across back-to-back writes; load_key drops it.
   task automatic write_register(input logic [2:0] index, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      case (index)
         CSR_KEY_WORD0:    key_words[0] = data;
         CSR_KEY_WORD1:    key_words[1] = data;
         CSR_KEY_WORD2:    key_words[2] = data;
         CSR_KEY_WORD3:    key_words[3] = data;
         CSR_KEY_LENGTH:   key_len = data[5:0];
         CSR_IV_HIGH:      iv_value.high = data;
         CSR_IV_LOW:       iv_value.low = data;
         CSR_DECRYPT_MODE: recover_mode = data[0];
         default: ;
      endcase
   endtask

   // Valid stays high into the next word unless an idle gap follows; wait_drained drops it.
   task automatic send_block(input logic [63:0] high, input logic [63:0] low,
                             input logic [4:0] count, input logic start);
      block_type text;
      if (!quiet_run && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      text.high = high;
      text.low  = low;
      req_valid         <= 1'b1;
      req_text_high     <= high;
      req_text_low      <= low;
      req_byte_count    <= count;
      req_start_message <= start;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(hide_block(text, count, start));
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_key(input int klen, input logic [63:0] iv_h, input logic [63:0] iv_l,
                           input logic mode);
      write_register(CSR_KEY_WORD0, {$urandom, $urandom});
      write_register(CSR_KEY_WORD1, {$urandom, $urandom});
      write_register(CSR_KEY_WORD2, {$urandom, $urandom});
      write_register(CSR_KEY_WORD3, {$urandom, $urandom});
      write_register(CSR_KEY_LENGTH, 64'(klen));
      write_register(CSR_IV_HIGH, iv_h);
      write_register(CSR_IV_LOW, iv_l);
      write_register(CSR_DECRYPT_MODE, 64'(mode));
      csr_write_enable <= 1'b0;
   endtask

   // Results are sampled at the clock edge and compared in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result word with no expectation: %h %h", rsp_result_high, rsp_result_low);
            error_count++;
         end else begin
            block_type exp_res;
            exp_res = expected_results.pop_front();
            if (rsp_result_high !== exp_res.high) begin
               $error("result_high expected %h actual %h", exp_res.high, rsp_result_high);
               error_count++;
            end
            if (rsp_result_low !== exp_res.low) begin
               $error("result_low expected %h actual %h", exp_res.low, rsp_result_low);
               error_count++;
            end
            results_seen++;
         end
      end
   end

   // Receiver stalls in random bursts, none once the quiet stretch begins.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet_run && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1_500_000) begin
         $display("md5_keystream_password_hiding_unit verification failed");
         $finish;
      end
   end

   task automatic test_extremes();
      load_key(0, '0, '0, 1'b0);
      send_block('0, '0, 5'd0, 1'b0);
      send_block('1, '1, 5'd16, 1'b0);
      send_block('1, '1, 5'd31, 1'b1);
      send_block('1, '1, 5'd1, 1'b0);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 1'b0);
      wait_drained();
      load_key(63, '1, '1, 1'b1);
      send_block('1, '1, 5'd16, 1'b1);
      send_block('1, '0, 5'd9, 1'b0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd15, 1'b0);
      wait_drained();
      load_key(32, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
      wait_drained();
      load_key(33, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd12, 1'b1);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b0);
      wait_drained();
   endtask

   // Random messages: a first word that mostly restarts the chain, then chained words, over several settings.
   task automatic test_random_messages(input int count);
      int sent;
      int klen;
      int msg_len;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 3))
            0: klen = 0;
            1: klen = 32;
            2: klen = $urandom_range(33, 63);
            default: klen = $urandom_range(1, 31);
         endcase
         load_key(klen, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
         repeat ($urandom_range(8, 20)) begin
            msg_len = $urandom_range(1, 8);
            for (int j = 0; j < msg_len; j++) begin
               send_block({$urandom, $urandom}, {$urandom, $urandom},
                          ($urandom_range(0, 9) == 0) ? 5'($urandom) :
                          5'($urandom_range(1, 16)),
                          (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0));
               sent++;
            end
         end
         wait_drained();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_text_high     <= '0;
      req_text_low      <= '0;
      req_byte_count    <= '0;
      req_start_message <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_KEY_WORD0;
      csr_write_data    <= '0;
      for (int i = 0; i < 4; i++) key_words[i] = '0;
      key_len = '0;
      iv_value = '0;
      recover_mode = 1'b0;
      chain = '0;
      error_count = 0;
      results_seen = 0;
      words_sent = 0;
      cycle_count = 0;
      quiet_run = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The first word runs on the chain's reset value.
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
      wait_drained();
      test_extremes();
      test_random_messages(1500);
      quiet_run = 1'b1;
      test_random_messages(200);
      wait_drained();
      $display("Sent %0d words through all key lengths, byte counts and both modes;",
               words_sent);
      $display("%0d result words compared against the predicted keystream.", results_seen);
      if (error_count == 0) begin
         $display("md5_keystream_password_hiding_unit verification clean");
      end else begin
         $display("md5_keystream_password_hiding_unit verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
